/* hdl/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that holds on every enabled clock edge
`define CHK_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// implication property
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`endif

/* hdl/fecg_pkg.sv */
// package: shared types and constants of the figure-eight curvature generator
// no dependencies
package fecg_pkg;
    localparam int DIST_BITS = 24;
    localparam int CFG_W     = 24;
    localparam int IDX_W     = 3;

    typedef enum logic [1:0] {
        OP_MODE = 2'd0,
        OP_DIST = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    localparam logic [IDX_W-1:0] REG_CYCLE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_PEAK     = 3'd1;
    localparam logic [IDX_W-1:0] REG_FALLBACK = 3'd2;
    localparam logic [IDX_W-1:0] REG_STRAIGHT = 3'd3;
    localparam logic [IDX_W-1:0] REG_RAMP     = 3'd4;
    localparam logic [IDX_W-1:0] REG_HOLD     = 3'd5;

    localparam logic [2:0] SEG_ZERO     = 3'd0;
    localparam logic [2:0] SEG_UP       = 3'd1;
    localparam logic [2:0] SEG_HOLD     = 3'd2;
    localparam logic [2:0] SEG_DOWN     = 3'd3;
    localparam logic [2:0] SEG_STRAIGHT = 3'd4;
    localparam logic [2:0] SEG_REST     = 3'd5;

    typedef struct packed {
        logic [1:0]           op;
        logic                 mode_on;
        logic [DIST_BITS-1:0] distance_in;
    } t_in;

    typedef struct packed {
        logic signed [24:0] radius;
        logic signed [16:0] curvature;
        logic [2:0]         segment;
        logic               second_half;
        logic               shares_scaled;
    } t_out;

    // divider request / response
    localparam int DIV_W = 48;
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } t_div_req;
    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] rem;
    } t_div_rsp;
endpackage

/* hdl/fecg_stream_if.sv */
// valid/ready channel interface
// depends on nothing; payload is a logic vector whose width is set by parameter W
interface fecg_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/fecg_div.sv */
// shared restoring divider, one quotient bit per cycle
// depends on fecg_pkg
module fecg_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fecg_pkg::t_div_req  i_req,
    output fecg_pkg::t_div_rsp  o_rsp
);
    import fecg_pkg::*;
    logic [DIV_W-1:0] r_quo, n_quo, r_rem, n_rem, r_den;
    logic [5:0]       r_cnt, n_cnt;
    logic             r_busy, n_busy, r_done, n_done;
    logic [DIV_W:0]   w_sh;

    always_comb begin
        n_quo = r_quo; n_rem = r_rem; n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        w_sh = {r_rem, r_quo[DIV_W-1]};
        if (i_req.start) begin
            n_quo = i_req.num; n_rem = '0; n_cnt = 6'(DIV_W); n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = DIV_W'(w_sh - {1'b0, r_den});
                n_quo = {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = w_sh[DIV_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_quo <= n_quo; r_rem <= n_rem;
        if (i_req.start) r_den <= i_req.den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;
endmodule

/* hdl/fecg_front.sv */
// front end: accepts items, keeps mode and distance, queues ready ticks
// depends on fecg_pkg
module fecg_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  fecg_pkg::t_in                 i_item,
    output logic                          o_q_valid,
    output logic [fecg_pkg::DIST_BITS-1:0] o_q_dist,
    input  logic                          i_q_pop
);
    import fecg_pkg::*;
    logic                 r_mode, r_dvalid;
    logic [DIST_BITS-1:0] r_dist;
    // two-entry tick queue
    logic [DIST_BITS-1:0] r_qd [2];
    logic                 r_wp, r_rp;
    logic [1:0]           r_cnt;
    logic                 w_acc, w_push;

    assign o_ready   = (r_cnt != 2'd2);
    assign w_acc     = i_valid && o_ready;
    assign w_push    = w_acc && (i_item.op == OP_TICK) && r_mode && r_dvalid;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_dist  = r_qd[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0; r_dvalid <= 1'b0; r_dist <= '0;
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (w_acc) begin
                case (i_item.op)
                    OP_MODE: begin
                        if (r_mode && !i_item.mode_on) begin
                            r_dist <= '0; r_dvalid <= 1'b0;
                        end
                        r_mode <= i_item.mode_on;
                    end
                    OP_DIST: begin
                        r_dist <= i_item.distance_in; r_dvalid <= 1'b1;
                    end
                    default: ;
                endcase
            end
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
        if (w_push) r_qd[r_wp] <= r_dist;
    end
endmodule

/* hdl/fecg_back.sv */
// back end: profile sequencer using the shared divider, registered result
// depends on fecg_pkg, fecg_div
module fecg_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  logic [fecg_pkg::DIST_BITS-1:0] i_q_dist,
    output logic                          o_q_pop,
    input  logic [23:0]                   i_cycle,
    input  logic [15:0]                   i_peak,
    input  logic [23:0]                   i_fallback,
    input  logic [15:0]                   i_straight,
    input  logic [15:0]                   i_ramp,
    input  logic [15:0]                   i_hold,
    output logic                          o_valid,
    input  logic                          i_ready,
    output fecg_pkg::t_out                o_res
);
    import fecg_pkg::*;
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SS    = 10'b0000000010,
        S_SR    = 10'b0000000100,
        S_SH    = 10'b0000001000,
        S_MOD   = 10'b0000010000,
        S_POS   = 10'b0000100000,
        S_SEG   = 10'b0001000000,
        S_MAG   = 10'b0010000000,
        S_RAD   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_st, n_st;
    logic   r_wait, n_wait;
    logic [15:0] r_s, r_r, r_h, n_s, n_r, n_h;
    logic [16:0] r_q, n_q;
    logic [16:0] r_mag, n_mag;
    logic [2:0]  r_seg, n_seg;
    logic        r_scl, n_scl;
    logic [23:0] r_d, n_d;
    logic [16:0] w_p_ext;
    logic [17:0] w_b1, w_b2, w_b3, w_b4, w_t;
    logic [40:0] w_kmul;
    logic [40:0] w_rmul;
    t_div_req w_req;
    t_div_rsp w_rsp;
    logic        r_ov, n_ov;
    t_out        r_res, n_res;
    logic        w_sec, w_neg;
    logic [24:0] w_rad;
    logic [15:0] w_p;

    fecg_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    assign w_t   = 18'(i_straight) + 18'(i_ramp) + 18'(i_hold);
    assign w_b1  = {1'b0, r_r, 1'b0};
    assign w_b2  = w_b1 + {1'b0, r_h, 1'b0};
    assign w_b3  = w_b2 + {1'b0, r_r, 1'b0};
    assign w_b4  = w_b3 + {1'b0, r_s, 1'b0};
    assign w_sec = r_q[16];
    assign w_p   = r_q[15:0];
    assign w_p_ext = {1'b0, w_p};
    assign w_kmul = 41'(i_peak) * 41'(r_d[17:0]);
    assign w_rmul = 41'(r_mag) * 41'(i_fallback);
    assign w_neg = w_sec && (r_mag != 17'd0);
    assign o_q_pop = (r_st == S_IDLE) && i_q_valid && !r_ov;

    always_comb begin
        n_st = r_st; n_wait = r_wait; n_s = r_s; n_r = r_r; n_h = r_h; n_q = r_q;
        n_mag = r_mag; n_seg = r_seg; n_scl = r_scl; n_d = r_d; n_ov = r_ov; n_res = r_res;
        w_req = '0;
        w_rad = '0;
        if (r_ov && i_ready) n_ov = 1'b0;
        case (r_st)
            S_IDLE: begin
                if (o_q_pop) begin
                    n_d = i_q_dist; n_s = i_straight; n_r = i_ramp; n_h = i_hold;
                    n_scl = (w_t > 18'd32768);
                    n_st = n_scl ? S_SS : S_MOD; n_wait = 1'b0;
                end
            end
            S_SS, S_SR, S_SH: begin
                if (!r_wait) begin
                    w_req.start = 1'b1;
                    w_req.den = DIV_W'(w_t);
                    w_req.num = (r_st == S_SS) ? DIV_W'({r_s, 15'd0}) :
                                (r_st == S_SR) ? DIV_W'({r_r, 15'd0}) :
                                                 DIV_W'({r_h, 15'd0});
                    n_wait = 1'b1;
                end else if (w_rsp.done) begin
                    n_wait = 1'b0;
                    case (r_st)
                        S_SS: begin n_s = w_rsp.quo[15:0]; n_st = S_SR; end
                        S_SR: begin n_r = w_rsp.quo[15:0]; n_st = S_SH; end
                        default: begin n_h = w_rsp.quo[15:0]; n_st = S_MOD; end
                    endcase
                end
            end
            S_MOD: begin
                if (i_cycle == 24'd0) begin
                    n_q = '0; n_st = S_SEG;
                end else if (!r_wait) begin
                    w_req.start = 1'b1;
                    w_req.num = DIV_W'(r_d); w_req.den = DIV_W'(i_cycle); n_wait = 1'b1;
                end else if (w_rsp.done) begin
                    n_wait = 1'b0; n_d = w_rsp.rem[23:0]; n_st = S_POS;
                end
            end
            S_POS: begin
                if (!r_wait) begin
                    w_req.start = 1'b1;
                    w_req.num = DIV_W'({r_d, 17'd0}); w_req.den = DIV_W'(i_cycle);
                    n_wait = 1'b1;
                end else if (w_rsp.done) begin
                    n_wait = 1'b0; n_q = w_rsp.quo[16:0]; n_st = S_SEG;
                end
            end
            S_SEG: begin
                // segment select; r_d reused as multiplier operand (ramp numerator)
                n_st = S_RAD; n_mag = '0;
                if ({1'b0, w_p_ext} <= w_b1) begin
                    if (r_r != 16'd0) begin
                        n_seg = SEG_UP; n_d = 24'(w_p); n_st = S_MAG;
                    end else n_seg = SEG_ZERO;
                end else if ({1'b0, w_p_ext} <= w_b2) begin
                    n_seg = SEG_HOLD; n_mag = 17'(i_peak);
                end else if ({1'b0, w_p_ext} <= w_b3) begin
                    n_seg = SEG_DOWN;
                    if (w_b1 != 18'd0) begin
                        n_d = 24'(w_b3 - {2'b0, w_p}); n_st = S_MAG;
                    end
                end else if ({1'b0, w_p_ext} <= w_b4) n_seg = SEG_STRAIGHT;
                else n_seg = SEG_REST;
            end
            S_MAG: begin
                if (!r_wait) begin
                    w_req.start = 1'b1;
                    w_req.num = DIV_W'(w_kmul); w_req.den = DIV_W'(w_b1); n_wait = 1'b1;
                end else if (w_rsp.done) begin
                    n_wait = 1'b0; n_mag = w_rsp.quo[16:0]; n_st = S_RAD;
                end
            end
            S_RAD: begin
                if (w_rmul < 41'd16777216) begin
                    n_res.radius = $signed({1'b0, i_fallback});
                    n_st = S_OUT;
                end else if (!r_wait) begin
                    w_req.start = 1'b1;
                    w_req.num = DIV_W'(25'd16777216); w_req.den = DIV_W'(r_mag);
                    n_wait = 1'b1;
                end else if (w_rsp.done) begin
                    n_wait = 1'b0;
                    w_rad = (w_rsp.quo > DIV_W'(24'hFFFFFF)) ? 25'hFFFFFF
                                                             : w_rsp.quo[24:0];
                    n_res.radius = w_neg ? $signed(-w_rad) : $signed(w_rad);
                    n_st = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ov) begin
                    n_res.curvature = w_neg ? $signed(-r_mag) : $signed(r_mag);
                    n_res.segment = r_seg;
                    n_res.second_half = w_sec;
                    n_res.shares_scaled = r_scl;
                    n_ov = 1'b1; n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_wait <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_wait <= n_wait; r_ov <= n_ov;
        end
        r_s <= n_s; r_r <= n_r; r_h <= n_h; r_q <= n_q; r_mag <= n_mag;
        r_seg <= n_seg; r_scl <= n_scl; r_d <= n_d; r_res <= n_res;
    end

    assign o_valid = r_ov;
    assign o_res   = r_res;
endmodule

/* hdl/figure_eight_curvature_generator.sv */
// top level: figure-eight curvature setpoint generator
// depends on fecg_pkg, fecg_stream_if, fecg_front, fecg_back
// per tick, the result waits on the shared one-bit-per-cycle divider for each
//   division it needs: up to three share scalings, the fold, the position,
//   the ramp and the reciprocal; input items wait while the tick queue is full
// throughput: a new tick starts the cycle after the previous result is taken
// synchronous active-low reset: mode off, no distance, configuration registers to defaults
module figure_eight_curvature_generator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    fecg_stream_if.sink        s_in,
    fecg_stream_if.source      m_out,
    input  logic               i_cfg_we,
    input  logic [fecg_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [fecg_pkg::CFG_W-1:0] i_cfg_data
);
    import fecg_pkg::*;
    // configuration registers
    logic [23:0] r_cycle, r_fallback;
    logic [15:0] r_peak, r_straight, r_ramp, r_hold;
    logic                 w_qv, w_pop;
    logic [DIST_BITS-1:0] w_qd;
    t_in                  w_in;
    t_out                 w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle <= 24'd14080; r_peak <= 16'd15984; r_fallback <= 24'd25600;
            r_straight <= 16'd655; r_ramp <= 16'd8192; r_hold <= 16'd16384;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CYCLE:    r_cycle    <= i_cfg_data;
                REG_PEAK:     r_peak     <= i_cfg_data[15:0];
                REG_FALLBACK: r_fallback <= i_cfg_data;
                REG_STRAIGHT: r_straight <= i_cfg_data[15:0];
                REG_RAMP:     r_ramp     <= i_cfg_data[15:0];
                REG_HOLD:     r_hold     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // payload is packed as op, mode_on, distance_in
    assign w_in = t_in'(s_in.data);

    // front: state update and tick queue
    fecg_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_in.valid), .o_ready(s_in.ready), .i_item(w_in),
        .o_q_valid(w_qv), .o_q_dist(w_qd), .i_q_pop(w_pop)
    );

    // back: profile evaluation and result register
    fecg_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(w_qv), .i_q_dist(w_qd), .o_q_pop(w_pop),
        .i_cycle(r_cycle), .i_peak(r_peak), .i_fallback(r_fallback),
        .i_straight(r_straight), .i_ramp(r_ramp), .i_hold(r_hold),
        .o_valid(m_out.valid), .i_ready(m_out.ready), .o_res(w_res)
    );

    assign m_out.data = $bits(m_out.data)'(w_res);
endmodule

/* hdl/fecg_checker.sv */
// port-level checker for the curvature generator, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"
module fecg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_ov,
    input logic        i_or,
    input logic [46:0] i_od
);
    `CHK_IMPLY(a_hold_valid, i_clk, i_rst_n, i_ov && !i_or, ##1 i_ov, "result dropped")
    `CHK_IMPLY(a_hold_data, i_clk, i_rst_n, i_ov && !i_or, ##1 $stable(i_od), "result changed")
    `CHK_ALWAYS(a_seg, i_clk, i_rst_n, !i_ov || i_od[4:2] <= 3'd5, "bad segment")
    `CHK_IMPLY(a_sign, i_clk, i_rst_n, i_ov && !i_od[1], !i_od[21], "negative curvature in first half")
endmodule

bind figure_eight_curvature_generator fecg_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_ov(m_out.valid), .i_or(m_out.ready), .i_od(m_out.data[46:0])
);
